>>> hdl/lcd3d_pkg.sv
// types, constants and glyph table for the three digit lcd driver
package lcd3d_pkg;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    localparam int unsigned NUM_COMS  = 4;
    localparam int unsigned SEG_W     = 6;
    localparam logic [SEG_W-1:0] ROW_RESET = '1;

    typedef struct packed {
        logic       kind;
        logic [3:0] digit0;
        logic [3:0] digit1;
        logic [3:0] digit2;
    } t_in_word;

    typedef struct packed {
        logic [NUM_COMS-1:0] com_enable;
        logic                com_level;
        logic [SEG_W-1:0]    seg_levels;
    } t_out_word;

    // 2-bit pattern per common packed at bit 2*common, blank above nine
    function automatic logic [7:0] glyph_rows(input logic [3:0] digit);
        logic [7:0] rows;
        case (digit)
            4'd0: rows = 8'hDE;
            4'd1: rows = 8'h14;
            4'd2: rows = 8'h7A;
            4'd3: rows = 8'h76;
            4'd4: rows = 8'hB4;
            4'd5: rows = 8'hE6;
            4'd6: rows = 8'hEE;
            4'd7: rows = 8'h54;
            4'd8: rows = 8'hFE;
            4'd9: rows = 8'hF6;
            default: rows = 8'h00;
        endcase
        return rows;
    endfunction

endpackage

>>> hdl/mux_lcd_three_digit_driver.sv
// three digit quarter duty multiplexed lcd driver, top level
// usage:
//   input channel (i_in_valid / o_in_ready / i_in_word) takes one word per
//   cycle. a load word (kind = 1) turns its three digits into four row words
//   and gives no output. a tick word (kind = 0) gives one output word with
//   the common enable, common level and segment levels for the current
//   phase, then the phase advances modulo 8.
//   output channel (o_out_valid / i_out_ready / o_out_word) carries one
//   word per tick, registered in the cycle after the tick is taken.
//   throughput is one word per cycle: lookup and row select sit between the
//   input handshake and the output register, so the output register is the
//   only stage.
//   when the receiver stalls, the output register holds its word and
//   o_in_ready drops until that word is taken.
//   reset (i_rst_n low, synchronous) clears the phase to 0, sets all four
//   rows to all ones and empties the output register.
module mux_lcd_three_digit_driver
    import lcd3d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic [2:0]       r_phase;
    logic [2:0]       n_phase;
    logic [SEG_W-1:0] r_rows [NUM_COMS];
    logic [SEG_W-1:0] n_rows [NUM_COMS];
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_word        r_out;
    t_out_word        n_out;
    logic             w_accept;
    logic [7:0]       w_g0;
    logic [7:0]       w_g1;
    logic [7:0]       w_g2;
    logic [1:0]       w_com;
    logic             w_first_half;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign w_g0         = glyph_rows(i_in_word.digit0);
    assign w_g1         = glyph_rows(i_in_word.digit1);
    assign w_g2         = glyph_rows(i_in_word.digit2);
    assign w_com        = r_phase[1:0];
    assign w_first_half = !r_phase[2];

    always_comb begin
        n_phase     = r_phase;
        n_rows      = r_rows;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        if (w_accept) begin
            if (i_in_word.kind == KIND_LOAD) begin
                for (int c = 0; c < NUM_COMS; c++) begin
                    n_rows[c] = {w_g0[2*c +: 2], w_g1[2*c +: 2], w_g2[2*c +: 2]};
                end
            end else begin
                n_out.com_enable = 4'(4'b0001 << w_com);
                n_out.com_level  = w_first_half;
                n_out.seg_levels = w_first_half ? ~r_rows[w_com] : r_rows[w_com];
                n_out_valid      = 1'b1;
                n_phase          = 3'(r_phase + 3'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < NUM_COMS; c++) begin
                r_rows[c] <= ROW_RESET;
            end
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_rows      <= n_rows;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_onehot_com: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot(r_out.com_enable))
        else $error("common enable not one-hot");

    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_word.kind == KIND_TICK) |=>
            (r_phase == 3'($past(r_phase) + 3'd1)))
        else $error("phase did not advance on tick");

    a_load_keeps_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_word.kind == KIND_LOAD) |=> $stable(r_phase))
        else $error("phase changed on load");

    a_load_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_word.kind == KIND_LOAD) |=> !r_out_valid)
        else $error("load produced an output word");

    a_level_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_word.kind == KIND_TICK) |=>
            (r_out.com_level == !$past(r_phase[2])))
        else $error("common level does not match phase half");
`endif

endmodule

>>> tb/tb_mux_lcd_three_digit_driver.sv
// self-checking testbench for the three digit multiplexed lcd driver
module tb_mux_lcd_three_digit_driver;
    import lcd3d_pkg::*;

    localparam int RANDOM_WORDS      = 750;
    localparam int LONG_STALL_AT     = 200;
    localparam int LONG_STALL_CYCLES = 300;
    localparam int DRAIN_CYCLES      = 10;
    localparam int CYCLE_LIMIT       = 200000;

    // segment pairs indexed [digit][common], digit 9 common 3 first
    localparam logic [9:0][3:0][1:0] SEG_PAIRS = {
        2'd3, 2'd3, 2'd1, 2'd2,
        2'd3, 2'd3, 2'd3, 2'd2,
        2'd1, 2'd1, 2'd1, 2'd0,
        2'd3, 2'd2, 2'd3, 2'd2,
        2'd3, 2'd2, 2'd1, 2'd2,
        2'd2, 2'd3, 2'd1, 2'd0,
        2'd1, 2'd3, 2'd1, 2'd2,
        2'd1, 2'd3, 2'd2, 2'd2,
        2'd0, 2'd1, 2'd1, 2'd0,
        2'd3, 2'd1, 2'd3, 2'd2
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    t_in_word         words_to_send [$];
    t_out_word        frames_due [$];
    logic [2:0]       lcd_phase;
    logic [SEG_W-1:0] lcd_rows [NUM_COMS];

    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    int   frames_taken = 0;
    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   tx_left = 0;
    int   rx_left = 0;
    logic tx_calm = 1'b0;
    logic rx_calm = 1'b0;

    mux_lcd_three_digit_driver uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [1:0] seg_pair(input logic [3:0] digit, input int common);
        if (digit > 4'd9) begin
            return 2'b00;
        end
        return SEG_PAIRS[digit][common];
    endfunction

    function automatic void refresh_display(input t_in_word w);
        t_out_word  frame;
        logic [1:0] com;
        if (w.kind == KIND_LOAD) begin
            for (int k = 0; k < NUM_COMS; k++) begin
                lcd_rows[k] = {seg_pair(w.digit0, k), seg_pair(w.digit1, k),
                               seg_pair(w.digit2, k)};
            end
        end else begin
            com              = lcd_phase[1:0];
            frame.com_enable = 4'b0001 << com;
            frame.com_level  = ~lcd_phase[2];
            frame.seg_levels = lcd_phase[2] ? lcd_rows[com] : ~lcd_rows[com];
            frames_due.push_back(frame);
            lcd_phase = lcd_phase + 3'd1;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic logic [3:0] rand_digit();
        if ($urandom_range(0, 9) == 0) begin
            return 4'($urandom_range(10, 15));
        end
        return 4'($urandom_range(0, 9));
    endfunction

    function automatic void queue_load(input logic [3:0] d0, input logic [3:0] d1,
                                       input logic [3:0] d2);
        t_in_word w;
        w.kind   = KIND_LOAD;
        w.digit0 = d0;
        w.digit1 = d1;
        w.digit2 = d2;
        words_to_send.push_back(w);
    endfunction

    function automatic void queue_tick();
        t_in_word w;
        w.kind   = KIND_TICK;
        w.digit0 = 4'($urandom_range(0, 15));
        w.digit1 = 4'($urandom_range(0, 15));
        w.digit2 = 4'($urandom_range(0, 15));
        words_to_send.push_back(w);
    endfunction

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_left = 0;
        end else if (!i_in_valid || in_taken) begin
            if (i_in_valid) begin
                if ($urandom_range(0, 49) == 0) begin
                    tx_calm = ~tx_calm;
                end
                tx_left = tx_calm ? 0 : $urandom_range(0, 13);
            end
            if (tx_left > 0) begin
                i_in_valid <= 1'b0;
                tx_left = tx_left - 1;
            end else if (words_to_send.size() > 0) begin
                i_in_word  <= words_to_send.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_left = 0;
        end else begin
            if (out_taken) begin
                if ($urandom_range(0, 49) == 0) begin
                    rx_calm = ~rx_calm;
                end
                rx_left = rx_calm ? 0 : $urandom_range(0, 13);
                if (frames_taken == LONG_STALL_AT) begin
                    rx_left = LONG_STALL_CYCLES;
                end
            end
            if (rx_left > 0) begin
                i_out_ready <= 1'b0;
                rx_left = rx_left - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
            lcd_phase = 3'd0;
            for (int k = 0; k < NUM_COMS; k++) begin
                lcd_rows[k] = ROW_RESET;
            end
            frames_due.delete();
        end else begin
            in_taken  <= i_in_valid && o_in_ready;
            out_taken <= o_out_valid && i_out_ready;
            if (o_out_valid && i_out_ready) begin
                frames_taken++;
                if (frames_due.size() == 0) begin
                    report_mismatch("output word with nothing expected");
                end else begin
                    want = frames_due.pop_front();
                    if (o_out_word.com_enable !== want.com_enable) begin
                        report_mismatch($sformatf("com_enable got %h expected %h",
                            o_out_word.com_enable, want.com_enable));
                    end
                    if (o_out_word.com_level !== want.com_level) begin
                        report_mismatch($sformatf("com_level got %b expected %b",
                            o_out_word.com_level, want.com_level));
                    end
                    if (o_out_word.seg_levels !== want.seg_levels) begin
                        report_mismatch($sformatf("seg_levels got %h expected %h",
                            o_out_word.seg_levels, want.seg_levels));
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                refresh_display(i_in_word);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        // ticks on the reset rows through every phase
        for (int k = 0; k < 8; k++) begin
            queue_tick();
        end
        queue_load(4'd0, 4'd1, 4'd2);
        for (int k = 0; k < 4; k++) begin
            queue_tick();
        end
        queue_load(4'd3, 4'd4, 4'd5);
        queue_load(4'd6, 4'd7, 4'd8);
        queue_tick();
        queue_tick();
        // blank positions
        queue_load(4'd9, 4'd15, 4'd10);
        queue_tick();
        queue_tick();
        queue_load(4'd15, 4'd15, 4'd15);
        queue_tick();
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if ($urandom_range(0, 3) == 0) begin
                queue_load(rand_digit(), rand_digit(), rand_digit());
            end else begin
                queue_tick();
            end
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (words_to_send.size() > 0 || i_in_valid || frames_due.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/lcd3d_pkg.sv
hdl/mux_lcd_three_digit_driver.sv
tb/tb_mux_lcd_three_digit_driver.sv
